@@ rtl/ucep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ucep_pkg;

    // Default packet size of endpoint zero
    localparam int unsigned PACKET_SIZE_DEF = 64;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 48;

    // Configuration port
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned LEN_W      = 16;

    // Register reset values
    localparam logic [7:0]  DEVICE_DESC_LEN_RST  = 8'd18;
    localparam logic [15:0] CONFIG_DESC_LEN_RST  = 16'd32;
    localparam logic [7:0]  STRING0_DESC_LEN_RST = 8'd4;
    localparam logic [7:0]  STRING1_DESC_LEN_RST = 8'd2;

    // Register indexes
    typedef enum logic [1:0] {
        REG_DEVICE_DESC_LEN  = 2'd0,
        REG_CONFIG_DESC_LEN  = 2'd1,
        REG_STRING0_DESC_LEN = 2'd2,
        REG_STRING1_DESC_LEN = 2'd3
    } cfg_reg_t;

    // Completed transaction kinds
    typedef enum logic [1:0] {
        MODE_SETUP = 2'd0,
        MODE_OUT   = 2'd1,
        MODE_IN    = 2'd2
    } mode_t;

    // Handshake codes
    typedef enum logic [1:0] {
        IN_STALL = 2'd0,
        IN_NAK   = 2'd1,
        IN_SEND  = 2'd2
    } in_reply_t;

    typedef enum logic [1:0] {
        OUT_STALL = 2'd0,
        OUT_NAK   = 2'd1,
        OUT_ACK   = 2'd2
    } out_reply_t;

    // IN data sources
    typedef enum logic [2:0] {
        SRC_NONE       = 3'd0,
        SRC_DEVICE     = 3'd1,
        SRC_CONFIG     = 3'd2,
        SRC_STRING0    = 3'd3,
        SRC_STRING1    = 3'd4,
        SRC_ZERO_WORD  = 3'd5,
        SRC_CONFIG_NUM = 3'd6,
        SRC_ZERO_BYTE  = 3'd7
    } tx_src_t;

    // Bulk endpoint actions
    typedef enum logic [2:0] {
        BULK_NONE     = 3'd0,
        BULK_DISABLE  = 3'd1,
        BULK_ENABLE   = 3'd2,
        BULK_CLR_OUT  = 3'd3,
        BULK_CLR_IN   = 3'd4
    } bulk_t;

    // Device state, one-hot
    typedef enum logic [2:0] {
        DEV_DEFAULT    = 3'b001,
        DEV_ADDRESSED  = 3'b010,
        DEV_CONFIGURED = 3'b100
    } dev_state_t;

    // Device state codes as reported
    localparam logic [1:0] DEV_CODE_DEFAULT    = 2'd0;
    localparam logic [1:0] DEV_CODE_ADDRESSED  = 2'd1;
    localparam logic [1:0] DEV_CODE_CONFIGURED = 2'd2;

    // Control transfer stage, one-hot
    typedef enum logic [3:0] {
        STAGE_IDLE       = 4'b0001,
        STAGE_DATA_IN    = 4'b0010,
        STAGE_STATUS_IN  = 4'b0100,
        STAGE_STATUS_OUT = 4'b1000
    } stage_t;

    // Request type decoding
    localparam logic [7:0] TYPE_KIND_MASK  = 8'h60;
    localparam logic [7:0] KIND_STANDARD   = 8'h00;
    localparam logic [7:0] KIND_CLASS      = 8'h20;
    localparam logic [7:0] TYPE_ENDPOINT   = 8'h02;

    // Request codes
    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_GET_MAX_LUN   = 8'hFE;
    localparam logic [7:0] REQ_STORAGE_RESET = 8'hFF;

    // Descriptor selectors (wValue)
    localparam logic [15:0] DESC_DEVICE  = 16'h0100;
    localparam logic [15:0] DESC_CONFIG  = 16'h0200;
    localparam logic [15:0] DESC_STRING0 = 16'h0300;
    localparam logic [15:0] DESC_STRING1 = 16'h0301;

    // Bulk endpoint numbers (wIndex)
    localparam logic [15:0] EP_BULK_OUT = 16'h0002;
    localparam logic [15:0] EP_BULK_IN  = 16'h0083;

    // One setup/transaction beat
    typedef struct packed {
        mode_t       mode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } req_t;

    // One result beat
    typedef struct packed {
        in_reply_t   in_reply;
        out_reply_t  out_reply;
        logic        out_zlp_only;
        tx_src_t     tx_source;
        logic [15:0] tx_offset;
        logic [6:0]  tx_count;
        logic        address_commit;
        logic [6:0]  address_value;
        bulk_t       bulk_action;
        logic        storage_reset;
        logic [1:0]  device_state_out;
        logic        config_value_out;
    } result_t;

    // Configuration as seen by the decoder, with packet-multiple flags
    typedef struct packed {
        logic [7:0]  device_desc_len;
        logic [15:0] config_desc_len;
        logic [7:0]  string0_desc_len;
        logic [7:0]  string1_desc_len;
        logic        device_mult;
        logic        config_mult;
        logic        string0_mult;
        logic        string1_mult;
    } cfg_t;

    // Endpoint zero state
    typedef struct packed {
        dev_state_t  dev;
        stage_t      stage;
        logic [15:0] bytes_left;
        logic [15:0] read_offset;
        logic        zlp_pending;
        logic [6:0]  pending_address;
        logic        active_config;
        tx_src_t     data_source;
    } ep_state_t;

    localparam ep_state_t EP_STATE_RST = '{
        dev:             DEV_DEFAULT,
        stage:           STAGE_IDLE,
        bytes_left:      16'd0,
        read_offset:     16'd0,
        zlp_pending:     1'b0,
        pending_address: 7'd0,
        active_config:   1'b0,
        data_source:     SRC_NONE
    };

endpackage

`default_nettype wire

@@ rtl/ucep_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ucep_cfg import ucep_pkg::*; #(
    parameter int unsigned PACKET_SIZE = PACKET_SIZE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire cfg_reg_t              cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    // Exact division by the packet size: multiply by a rounded-up reciprocal
    localparam int unsigned LOG2P  = $clog2(PACKET_SIZE);
    localparam int unsigned SHIFT  = LEN_W + LOG2P;
    localparam int unsigned RECIP_W = LEN_W + 1;
    localparam int unsigned PROD_W = SHIFT + LEN_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << SHIFT) / PACKET_SIZE + 1);

    function automatic logic pkt_mult(input logic [LEN_W-1:0] len);
        logic [PROD_W-1:0] prod;
        logic [LEN_W-1:0]  quo;
        logic [LEN_W-1:0]  back;
        prod = PROD_W'(len) * PROD_W'(RECIP);
        quo  = prod[SHIFT +: LEN_W];
        back = LEN_W'(quo * PACKET_SIZE);
        return back == len;
    endfunction

    logic [7:0]  device_len_reg;
    logic [15:0] config_len_reg;
    logic [7:0]  string0_len_reg;
    logic [7:0]  string1_len_reg;
    logic        device_mult_reg;
    logic        config_mult_reg;
    logic        string0_mult_reg;
    logic        string1_mult_reg;

    // Register writes; the multiple-of-packet flag is taken with the length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_len_reg   <= DEVICE_DESC_LEN_RST;
            config_len_reg   <= CONFIG_DESC_LEN_RST;
            string0_len_reg  <= STRING0_DESC_LEN_RST;
            string1_len_reg  <= STRING1_DESC_LEN_RST;
            device_mult_reg  <= pkt_mult(LEN_W'(DEVICE_DESC_LEN_RST));
            config_mult_reg  <= pkt_mult(CONFIG_DESC_LEN_RST);
            string0_mult_reg <= pkt_mult(LEN_W'(STRING0_DESC_LEN_RST));
            string1_mult_reg <= pkt_mult(LEN_W'(STRING1_DESC_LEN_RST));
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEVICE_DESC_LEN: begin
                    device_len_reg  <= cfg_wdata[7:0];
                    device_mult_reg <= pkt_mult(LEN_W'(cfg_wdata[7:0]));
                end
                REG_CONFIG_DESC_LEN: begin
                    config_len_reg  <= cfg_wdata;
                    config_mult_reg <= pkt_mult(cfg_wdata);
                end
                REG_STRING0_DESC_LEN: begin
                    string0_len_reg  <= cfg_wdata[7:0];
                    string0_mult_reg <= pkt_mult(LEN_W'(cfg_wdata[7:0]));
                end
                REG_STRING1_DESC_LEN: begin
                    string1_len_reg  <= cfg_wdata[7:0];
                    string1_mult_reg <= pkt_mult(LEN_W'(cfg_wdata[7:0]));
                end
            endcase
        end
    end

    assign cfg.device_desc_len  = device_len_reg;
    assign cfg.config_desc_len  = config_len_reg;
    assign cfg.string0_desc_len = string0_len_reg;
    assign cfg.string1_desc_len = string1_len_reg;
    assign cfg.device_mult      = device_mult_reg;
    assign cfg.config_mult      = config_mult_reg;
    assign cfg.string0_mult     = string0_mult_reg;
    assign cfg.string1_mult     = string1_mult_reg;

endmodule

`default_nettype wire

@@ rtl/ucep_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ucep_core import ucep_pkg::*; #(
    parameter int unsigned PACKET_SIZE = PACKET_SIZE_DEF
) (
    input  wire req_t      req,
    input  wire cfg_t      cfg,
    input  wire ep_state_t cur,
    output ep_state_t      state_next,
    output result_t        res
);

    localparam logic [15:0] PKT     = 16'(PACKET_SIZE);
    localparam logic [6:0]  PKT_CNT = 7'(PACKET_SIZE);

    function automatic logic [1:0] dev_code(input dev_state_t d);
        logic [1:0] c;
        unique case (d)
            DEV_ADDRESSED:  c = DEV_CODE_ADDRESSED;
            DEV_CONFIGURED: c = DEV_CODE_CONFIGURED;
            default:        c = DEV_CODE_DEFAULT;
        endcase
        return c;
    endfunction

    logic        is_dflt, is_addr, is_conf;
    logic [7:0]  kind;
    logic        desc_hit;
    tx_src_t     desc_src;
    logic [15:0] desc_size;
    logic        desc_mult;
    logic        desc_short;
    logic [15:0] desc_len;
    in_reply_t   hold_in;
    out_reply_t  hold_out;
    logic        hold_zlp;

    assign is_dflt = (cur.dev == DEV_DEFAULT);
    assign is_addr = (cur.dev == DEV_ADDRESSED);
    assign is_conf = (cur.dev == DEV_CONFIGURED);
    assign kind    = req.request_type & TYPE_KIND_MASK;

    // Descriptor selection and first transfer length
    always_comb begin
        desc_hit  = 1'b1;
        desc_src  = SRC_NONE;
        desc_size = 16'd0;
        desc_mult = 1'b0;
        priority if (req.request_value == DESC_DEVICE) begin
            desc_src  = SRC_DEVICE;
            desc_size = {8'h00, cfg.device_desc_len};
            desc_mult = cfg.device_mult;
        end else if (req.request_value == DESC_CONFIG) begin
            desc_src  = SRC_CONFIG;
            desc_size = cfg.config_desc_len;
            desc_mult = cfg.config_mult;
        end else if (req.request_value == DESC_STRING0) begin
            desc_src  = SRC_STRING0;
            desc_size = {8'h00, cfg.string0_desc_len};
            desc_mult = cfg.string0_mult;
        end else if (req.request_value == DESC_STRING1) begin
            desc_src  = SRC_STRING1;
            desc_size = {8'h00, cfg.string1_desc_len};
            desc_mult = cfg.string1_mult;
        end else begin
            desc_hit = 1'b0;
        end
    end

    assign desc_short = (desc_size < req.request_length);
    assign desc_len   = desc_short ? desc_size : req.request_length;

    // Handshakes that the current stage keeps giving
    always_comb begin
        unique case (cur.stage)
            STAGE_DATA_IN: begin
                hold_in = IN_SEND;  hold_out = OUT_NAK;   hold_zlp = 1'b0;
            end
            STAGE_STATUS_IN: begin
                hold_in = IN_SEND;  hold_out = OUT_STALL; hold_zlp = 1'b0;
            end
            STAGE_STATUS_OUT: begin
                hold_in = IN_STALL; hold_out = OUT_ACK;   hold_zlp = 1'b1;
            end
            default: begin
                hold_in = IN_STALL; hold_out = OUT_STALL; hold_zlp = 1'b0;
            end
        endcase
    end

    // Transaction decode
    always_comb begin
        state_next       = cur;
        res              = '0;
        res.in_reply     = hold_in;
        res.out_reply    = hold_out;
        res.out_zlp_only = hold_zlp;

        unique case (req.mode)
            MODE_SETUP: begin
                state_next.read_offset = 16'd0;
                state_next.bytes_left  = 16'd0;
                state_next.zlp_pending = 1'b0;
                state_next.stage       = STAGE_IDLE;
                res.in_reply     = IN_STALL;
                res.out_reply    = OUT_STALL;
                res.out_zlp_only = 1'b0;
                if (kind == KIND_STANDARD) begin
                    priority if (req.request_code == REQ_GET_DESC) begin
                        if (desc_hit) begin
                            state_next.data_source = desc_src;
                            state_next.stage       = STAGE_DATA_IN;
                            state_next.zlp_pending = desc_short && desc_mult;
                            res.in_reply = IN_SEND;
                            if (desc_len <= PKT) begin
                                if (desc_len != 16'd0) begin
                                    res.tx_source = desc_src;
                                    res.tx_count  = desc_len[6:0];
                                end
                                res.out_reply = OUT_NAK;
                            end else begin
                                res.tx_source          = desc_src;
                                res.tx_count           = PKT_CNT;
                                state_next.read_offset = PKT;
                                state_next.bytes_left  = desc_len - PKT;
                            end
                        end
                    end else if (req.request_code == REQ_SET_ADDRESS &&
                                 (is_dflt || is_addr)) begin
                        state_next.pending_address = req.request_value[6:0];
                        state_next.dev = (req.request_value[6:0] != 7'd0) ?
                                         DEV_ADDRESSED : DEV_DEFAULT;
                        state_next.stage = STAGE_STATUS_IN;
                        res.in_reply     = IN_SEND;
                    end else if (req.request_code == REQ_GET_CONFIG &&
                                 (is_addr || is_conf)) begin
                        state_next.data_source = SRC_CONFIG_NUM;
                        state_next.stage       = STAGE_DATA_IN;
                        res.tx_source = SRC_CONFIG_NUM;
                        res.tx_count  = 7'd1;
                        res.in_reply  = IN_SEND;
                        res.out_reply = OUT_NAK;
                    end else if (req.request_code == REQ_GET_STATUS &&
                                 (is_addr || is_conf)) begin
                        state_next.data_source = SRC_ZERO_WORD;
                        state_next.stage       = STAGE_DATA_IN;
                        res.tx_source = SRC_ZERO_WORD;
                        res.tx_count  = 7'd2;
                        res.in_reply  = IN_SEND;
                        res.out_reply = OUT_NAK;
                    end else if (req.request_code == REQ_SET_CONFIG &&
                                 (is_addr || is_conf) &&
                                 req.request_value[15:1] == 15'd0) begin
                        state_next.active_config = req.request_value[0];
                        state_next.dev = req.request_value[0] ?
                                         DEV_CONFIGURED : DEV_ADDRESSED;
                        res.bulk_action = req.request_value[0] ?
                                          BULK_ENABLE : BULK_DISABLE;
                        state_next.stage = STAGE_STATUS_IN;
                        res.in_reply     = IN_SEND;
                    end else if (req.request_code == REQ_CLEAR_FEATURE && is_conf &&
                                 req.request_value == 16'd0 &&
                                 req.request_type == TYPE_ENDPOINT &&
                                 (req.request_index == EP_BULK_OUT ||
                                  req.request_index == EP_BULK_IN)) begin
                        res.bulk_action = (req.request_index == EP_BULK_OUT) ?
                                          BULK_CLR_OUT : BULK_CLR_IN;
                        state_next.stage = STAGE_STATUS_IN;
                        res.in_reply     = IN_SEND;
                    end else begin
                        res.in_reply = IN_STALL;
                    end
                end else if (kind == KIND_CLASS && is_conf &&
                             req.request_index == 16'd0) begin
                    if (req.request_code == REQ_GET_MAX_LUN) begin
                        state_next.data_source = SRC_ZERO_BYTE;
                        state_next.stage       = STAGE_DATA_IN;
                        res.tx_source = SRC_ZERO_BYTE;
                        res.tx_count  = 7'd1;
                        res.in_reply  = IN_SEND;
                        res.out_reply = OUT_NAK;
                    end else if (req.request_code == REQ_STORAGE_RESET) begin
                        res.storage_reset = 1'b1;
                        state_next.stage  = STAGE_STATUS_IN;
                        res.in_reply      = IN_SEND;
                    end
                end
            end

            MODE_OUT: begin
                // status-out completes the transfer
                if (cur.stage == STAGE_STATUS_OUT) begin
                    state_next.stage = STAGE_IDLE;
                    res.in_reply     = IN_STALL;
                    res.out_reply    = OUT_STALL;
                    res.out_zlp_only = 1'b0;
                end
            end

            MODE_IN: begin
                if (cur.stage == STAGE_DATA_IN) begin
                    priority if (cur.bytes_left == 16'd0 && cur.zlp_pending) begin
                        // zero-length packet closes the data stage
                        state_next.zlp_pending = 1'b0;
                        res.in_reply  = IN_SEND;
                        res.out_reply = OUT_NAK;
                    end else if (cur.bytes_left == 16'd0) begin
                        state_next.stage = STAGE_STATUS_OUT;
                        res.in_reply     = IN_STALL;
                        res.out_reply    = OUT_ACK;
                        res.out_zlp_only = 1'b1;
                    end else if (cur.bytes_left <= PKT) begin
                        res.tx_source = cur.data_source;
                        res.tx_offset = cur.read_offset;
                        res.tx_count  = cur.bytes_left[6:0];
                        state_next.bytes_left = 16'd0;
                        res.in_reply  = IN_SEND;
                        res.out_reply = OUT_NAK;
                    end else begin
                        res.tx_source = cur.data_source;
                        res.tx_offset = cur.read_offset;
                        res.tx_count  = PKT_CNT;
                        state_next.read_offset = cur.read_offset + PKT;
                        state_next.bytes_left  = cur.bytes_left - PKT;
                        res.in_reply  = IN_SEND;
                        res.out_reply = OUT_STALL;
                    end
                end else if (cur.stage == STAGE_STATUS_IN) begin
                    // status-in done: commit the pending address
                    res.address_commit = 1'b1;
                    res.address_value  = cur.pending_address;
                    state_next.stage   = STAGE_IDLE;
                    res.in_reply       = IN_STALL;
                    res.out_reply      = OUT_STALL;
                end
            end

            default: begin
                // undefined transaction: hold
            end
        endcase

        res.device_state_out = dev_code(state_next.dev);
        res.config_value_out = state_next.active_config;
    end

endmodule

`default_nettype wire

@@ rtl/usb_control_endpoint_fsm_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Endpoint-zero control engine of a USB mass-storage device.
// s_ channel: one beat per completed transaction on endpoint zero (setup,
// out or in) with the setup packet fields. m_ channel: exactly one result
// beat per input beat, in order: next IN/OUT handshakes, the IN packet to
// load (source, offset, count), address commit, bulk endpoint action,
// storage reset pulse and the device state.
// cfg_ port: descriptor lengths, one register per cycle; the user must
// write only while no transaction is in flight; the block does not check.
// A beat is held in the input register, decoded combinationally and its
// result loaded into the result register that drives m_tdata.
// Throughput: one beat per cycle unless m_ stalls; a two-stage pipeline.
// A stalled m_ side holds its beat; one more input beat is taken into the
// input register, then s_tready drops until the result moves on.
// Reset (aresetn low, synchronous) empties both stages, returns the device
// to the default state with an idle transfer and reloads the descriptor
// lengths with their defaults.
module usb_control_endpoint_fsm_top import ucep_pkg::*; #(
    parameter int unsigned PACKET_SIZE = PACKET_SIZE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // mode[1:0], request_type[9:2], request_code[17:10],
    // request_value[33:18], request_index[49:34], request_length[65:50]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // in_reply[1:0], out_reply[3:2], out_zlp_only[4], tx_source[7:5],
    // tx_offset[23:8], tx_count[30:24], address_commit[31],
    // address_value[38:32], bulk_action[41:39], storage_reset[42],
    // device_state_out[44:43], config_value_out[45]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      in_valid_reg;
    req_t      in_req_reg;
    logic      out_valid_reg;
    result_t   out_res_reg;
    ep_state_t state_reg;
    ep_state_t state_next;
    result_t   res_next;
    cfg_t      cfg;
    req_t      s_req;
    logic      advance;

    // Register file
    ucep_cfg #(
        .PACKET_SIZE(PACKET_SIZE)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_reg_t'(cfg_addr)),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the input beat
    assign s_req.mode           = mode_t'(s_tdata[1:0]);
    assign s_req.request_type   = s_tdata[9:2];
    assign s_req.request_code   = s_tdata[17:10];
    assign s_req.request_value  = s_tdata[33:18];
    assign s_req.request_index  = s_tdata[49:34];
    assign s_req.request_length = s_tdata[65:50];

    // Pipeline flow control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Decoder
    ucep_core #(
        .PACKET_SIZE(PACKET_SIZE)
    ) u_core (
        .req        (in_req_reg),
        .cfg        (cfg),
        .cur        (state_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= EP_STATE_RST;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= s_req;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.config_value_out,
                       out_res_reg.device_state_out,
                       out_res_reg.storage_reset,
                       out_res_reg.bulk_action,
                       out_res_reg.address_value,
                       out_res_reg.address_commit,
                       out_res_reg.tx_count,
                       out_res_reg.tx_offset,
                       out_res_reg.tx_source,
                       out_res_reg.out_zlp_only,
                       out_res_reg.out_reply,
                       out_res_reg.in_reply};

endmodule

`default_nettype wire

@@ rtl/ucep_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ucep_checker import ucep_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Address value only accompanies a commit
    a_addr_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[31] |-> m_tdata[38:32] == 7'd0)
        else $error("address value without commit");

    // Storage reset only in configured state, going to status-in
    a_storage_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[42] |->
            m_tdata[44:43] == DEV_CODE_CONFIGURED && m_tdata[1:0] == IN_SEND)
        else $error("storage reset outside configured state");

    // Packet never exceeds the largest packet, and no count without a source
    a_tx_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:24] <= 7'd64 &&
            (m_tdata[7:5] != SRC_NONE || m_tdata[30:24] == 7'd0))
        else $error("bad IN packet count");

endmodule

bind usb_control_endpoint_fsm_top ucep_checker u_ucep_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/ep0_result_check.sv @@
`timescale 1ns / 1ps

module ep0_result_check import ucep_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    replies_owed
);

    localparam logic [15:0] PKT = 16'(PACKET_SIZE_DEF);

    // Descriptor lengths as programmed
    logic [7:0]  dev_desc_len;
    logic [15:0] cfg_desc_len;
    logic [7:0]  str0_desc_len;
    logic [7:0]  str1_desc_len;

    // Shadow of the endpoint zero state
    logic [1:0]  dev_code;
    stage_t      stage;
    logic [15:0] bytes_left;
    logic [15:0] read_offset;
    logic        zlp_owed;
    logic [6:0]  pend_addr;
    logic        cur_config;
    tx_src_t     cur_source;

    // Reply being built for the current beat, and replies still to come
    result_t rep;
    result_t replies_due[$];

    initial begin
        mismatches   = 0;
        replies_owed = 0;
    end

    function automatic void set_hs(input in_reply_t in_rep, input out_reply_t out_rep,
                                   input logic zlp_only);
        rep.in_reply     = in_rep;
        rep.out_reply    = out_rep;
        rep.out_zlp_only = zlp_only;
    endfunction

    function automatic void stall_both();
        set_hs(IN_STALL, OUT_STALL, 1'b0);
    endfunction

    // Stray IN/OUT: repeat what the current stage answers
    function automatic void hold_hs();
        case (stage)
            STAGE_DATA_IN:    set_hs(IN_SEND, OUT_NAK, 1'b0);
            STAGE_STATUS_IN:  set_hs(IN_SEND, OUT_STALL, 1'b0);
            STAGE_STATUS_OUT: set_hs(IN_STALL, OUT_ACK, 1'b1);
            default:          stall_both();
        endcase
    endfunction

    function automatic void load_packet(input tx_src_t src, input logic [15:0] offset,
                                        input logic [15:0] count);
        rep.tx_source = src;
        rep.tx_offset = offset;
        rep.tx_count  = count[6:0];
    endfunction

    function automatic void short_reply(input tx_src_t src, input logic [15:0] count);
        cur_source = src;
        stage      = STAGE_DATA_IN;
        bytes_left = '0;
        load_packet(src, 16'd0, count);
        set_hs(IN_SEND, OUT_NAK, 1'b0);
    endfunction

    function automatic void enter_status_in();
        stage      = STAGE_STATUS_IN;
        bytes_left = '0;
        set_hs(IN_SEND, OUT_STALL, 1'b0);
    endfunction

    function automatic void fetch_desc(input logic [15:0] value, input logic [15:0] length);
        tx_src_t     src;
        logic [15:0] size;
        case (value)
            DESC_DEVICE:  begin src = SRC_DEVICE;  size = {8'd0, dev_desc_len};  end
            DESC_CONFIG:  begin src = SRC_CONFIG;  size = cfg_desc_len;          end
            DESC_STRING0: begin src = SRC_STRING0; size = {8'd0, str0_desc_len}; end
            DESC_STRING1: begin src = SRC_STRING1; size = {8'd0, str1_desc_len}; end
            default: begin
                stall_both();
                return;
            end
        endcase
        cur_source = src;
        stage      = STAGE_DATA_IN;
        // short descriptor on a packet boundary needs a closing zero-length packet
        if (size < length) begin
            bytes_left = size;
            if (size % PKT == 16'd0) zlp_owed = 1'b1;
        end else begin
            bytes_left = length;
        end
        if (bytes_left <= PKT) begin
            if (bytes_left != 16'd0) load_packet(src, 16'd0, bytes_left);
            bytes_left = '0;
            set_hs(IN_SEND, OUT_NAK, 1'b0);
        end else begin
            load_packet(src, 16'd0, PKT);
            read_offset = PKT;
            bytes_left  = bytes_left - PKT;
            set_hs(IN_SEND, OUT_STALL, 1'b0);
        end
    endfunction

    function automatic void standard_req(input logic [7:0] rtype, input logic [7:0] code,
                                         input logic [15:0] value, input logic [15:0] index,
                                         input logic [15:0] length);
        if (code == REQ_GET_DESC) begin
            fetch_desc(value, length);
        end else if (code == REQ_SET_ADDRESS && dev_code != DEV_CODE_CONFIGURED) begin
            pend_addr = value[6:0];
            dev_code  = (value[6:0] != 7'd0) ? DEV_CODE_ADDRESSED : DEV_CODE_DEFAULT;
            stage     = STAGE_STATUS_IN;
            set_hs(IN_SEND, OUT_STALL, 1'b0);
        end else if (code == REQ_GET_CONFIG && dev_code != DEV_CODE_DEFAULT) begin
            short_reply(SRC_CONFIG_NUM, 16'd1);
        end else if (code == REQ_GET_STATUS && dev_code != DEV_CODE_DEFAULT) begin
            short_reply(SRC_ZERO_WORD, 16'd2);
        end else if (code == REQ_SET_CONFIG && dev_code != DEV_CODE_DEFAULT
                     && value <= 16'd1) begin
            cur_config      = value[0];
            dev_code        = value[0] ? DEV_CODE_CONFIGURED : DEV_CODE_ADDRESSED;
            rep.bulk_action = value[0] ? BULK_ENABLE : BULK_DISABLE;
            stage           = STAGE_STATUS_IN;
            set_hs(IN_SEND, OUT_STALL, 1'b0);
        end else if (code == REQ_CLEAR_FEATURE && dev_code == DEV_CODE_CONFIGURED
                     && value == 16'd0 && rtype == TYPE_ENDPOINT
                     && (index == EP_BULK_OUT || index == EP_BULK_IN)) begin
            rep.bulk_action = (index == EP_BULK_OUT) ? BULK_CLR_OUT : BULK_CLR_IN;
            stage           = STAGE_STATUS_IN;
            set_hs(IN_SEND, OUT_STALL, 1'b0);
        end else begin
            stall_both();
        end
    endfunction

    // Mass-storage class requests, only when configured and aimed at interface 0
    function automatic void class_req(input logic [7:0] code, input logic [15:0] index);
        if (dev_code != DEV_CODE_CONFIGURED || index != 16'd0) begin
            stall_both();
        end else if (code == REQ_GET_MAX_LUN) begin
            short_reply(SRC_ZERO_BYTE, 16'd1);
        end else if (code == REQ_STORAGE_RESET) begin
            rep.storage_reset = 1'b1;
            enter_status_in();
        end else begin
            stall_both();
        end
    endfunction

    function automatic void in_done();
        if (stage == STAGE_DATA_IN) begin
            if (bytes_left == 16'd0 && zlp_owed) begin
                zlp_owed = 1'b0;
                set_hs(IN_SEND, OUT_NAK, 1'b0);
            end else if (bytes_left == 16'd0) begin
                stage = STAGE_STATUS_OUT;
                set_hs(IN_STALL, OUT_ACK, 1'b1);
            end else if (bytes_left <= PKT) begin
                load_packet(cur_source, read_offset, bytes_left);
                bytes_left = '0;
                set_hs(IN_SEND, OUT_NAK, 1'b0);
            end else begin
                load_packet(cur_source, read_offset, PKT);
                read_offset = read_offset + PKT;
                bytes_left  = bytes_left - PKT;
                set_hs(IN_SEND, OUT_STALL, 1'b0);
            end
        end else if (stage == STAGE_STATUS_IN) begin
            // any finished status-in stage applies the pending address
            rep.address_commit = 1'b1;
            rep.address_value  = pend_addr;
            stage              = STAGE_IDLE;
            stall_both();
        end else begin
            hold_hs();
        end
    endfunction

    // Expected reply for one transaction beat; advances the shadow state
    function automatic result_t ep0_decide(input logic [S_TDATA_W-1:0] beat);
        logic [1:0]  mode;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        mode   = beat[1:0];
        rtype  = beat[9:2];
        code   = beat[17:10];
        value  = beat[33:18];
        index  = beat[49:34];
        length = beat[65:50];
        rep    = '0;
        case (mode)
            MODE_SETUP: begin
                // a setup aborts whatever transfer was running
                read_offset = '0;
                bytes_left  = '0;
                zlp_owed    = 1'b0;
                stage       = STAGE_IDLE;
                if ((rtype & TYPE_KIND_MASK) == KIND_STANDARD) begin
                    standard_req(rtype, code, value, index, length);
                end else if ((rtype & TYPE_KIND_MASK) == KIND_CLASS) begin
                    class_req(code, index);
                end else begin
                    stall_both();
                end
            end
            MODE_OUT: begin
                if (stage == STAGE_STATUS_OUT) begin
                    stage = STAGE_IDLE;
                    stall_both();
                end else begin
                    hold_hs();
                end
            end
            MODE_IN: in_done();
            default: hold_hs();
        endcase
        rep.device_state_out = dev_code;
        rep.config_value_out = cur_config;
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Watch all three ports; compare results before taking the new beat
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            dev_desc_len  = DEVICE_DESC_LEN_RST;
            cfg_desc_len  = CONFIG_DESC_LEN_RST;
            str0_desc_len = STRING0_DESC_LEN_RST;
            str1_desc_len = STRING1_DESC_LEN_RST;
            dev_code      = DEV_CODE_DEFAULT;
            stage         = STAGE_IDLE;
            bytes_left    = '0;
            read_offset   = '0;
            zlp_owed      = 1'b0;
            pend_addr     = '0;
            cur_config    = 1'b0;
            cur_source    = SRC_NONE;
            replies_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEVICE_DESC_LEN:  dev_desc_len  = cfg_wdata[7:0];
                    REG_CONFIG_DESC_LEN:  cfg_desc_len  = cfg_wdata[15:0];
                    REG_STRING0_DESC_LEN: str0_desc_len = cfg_wdata[7:0];
                    default:              str1_desc_len = cfg_wdata[7:0];
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.in_reply         = in_reply_t'(m_tdata[1:0]);
                got.out_reply        = out_reply_t'(m_tdata[3:2]);
                got.out_zlp_only     = m_tdata[4];
                got.tx_source        = tx_src_t'(m_tdata[7:5]);
                got.tx_offset        = m_tdata[23:8];
                got.tx_count         = m_tdata[30:24];
                got.address_commit   = m_tdata[31];
                got.address_value    = m_tdata[38:32];
                got.bulk_action      = bulk_t'(m_tdata[41:39]);
                got.storage_reset    = m_tdata[42];
                got.device_state_out = m_tdata[44:43];
                got.config_value_out = m_tdata[45];
                if (replies_due.size() == 0) begin
                    $error("result beat with no transaction outstanding");
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("in_reply", want.in_reply, got.in_reply);
                    check_field("out_reply", want.out_reply, got.out_reply);
                    check_field("out_zlp_only", want.out_zlp_only, got.out_zlp_only);
                    check_field("tx_source", want.tx_source, got.tx_source);
                    check_field("tx_offset", want.tx_offset, got.tx_offset);
                    check_field("tx_count", want.tx_count, got.tx_count);
                    check_field("address_commit", want.address_commit, got.address_commit);
                    check_field("address_value", want.address_value, got.address_value);
                    check_field("bulk_action", want.bulk_action, got.bulk_action);
                    check_field("storage_reset", want.storage_reset, got.storage_reset);
                    check_field("device_state_out", want.device_state_out,
                                got.device_state_out);
                    check_field("config_value_out", want.config_value_out,
                                got.config_value_out);
                end
            end
            if (s_tvalid && s_tready) replies_due.push_back(ep0_decide(s_tdata));
        end
        replies_owed = replies_due.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ucep_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = 60;

    // Mode code the block does not define; it must answer like a stray beat
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int replies_owed;
    int quiet_cycles = 0;
    int sent_items   = 0;
    bit no_gaps      = 1'b0;

    // Descriptor lengths as last programmed, to size the data stages
    logic [7:0]  dev_len  = DEVICE_DESC_LEN_RST;
    logic [15:0] conf_len = CONFIG_DESC_LEN_RST;
    logic [7:0]  str0_len = STRING0_DESC_LEN_RST;
    logic [7:0]  str1_len = STRING1_DESC_LEN_RST;

    always #1 aclk = ~aclk;

    usb_control_endpoint_fsm_top DUT (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .cfg_we,
        .cfg_addr,
        .cfg_wdata
    );

    ep0_result_check u_check (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .cfg_we,
        .cfg_addr,
        .cfg_wdata,
        .mismatches,
        .replies_owed
    );

    // Watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stall before each beat
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // One transaction beat, after a random gap; returns at the next falling edge
    task automatic send_txn(input logic [1:0] mode, input logic [7:0] rtype,
                            input logic [7:0] code, input logic [15:0] value,
                            input logic [15:0] index, input logic [15:0] length);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, length, index, value, code, rtype, mode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_items++;
    endtask

    // Beat of the given mode with random setup fields, which IN and OUT must ignore
    task automatic complete(input logic [1:0] mode);
        send_txn(mode, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (replies_owed != 0) @(negedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic program_lengths(input logic [7:0] d, input logic [15:0] c,
                                   input logic [7:0] s0, input logic [7:0] s1);
        put_reg(REG_DEVICE_DESC_LEN, {8'd0, d});
        put_reg(REG_CONFIG_DESC_LEN, c);
        put_reg(REG_STRING0_DESC_LEN, {8'd0, s0});
        put_reg(REG_STRING1_DESC_LEN, {8'd0, s1});
        cfg_we   <= 1'b0;
        dev_len  = d;
        conf_len = c;
        str0_len = s0;
        str1_len = s1;
    endtask

    function automatic logic [7:0] pick_len8();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd64;
            2:       return 8'd255;
            default: return 8'($urandom_range(1, 200));
        endcase
    endfunction

    // One control transfer, mostly well formed, sometimes cut short or plain noise
    task automatic random_transfer();
        int          pick;
        int          n_in;
        int          shown;
        bit          with_out;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        logic [15:0] size;
        pick     = $urandom_range(0, 99);
        n_in     = 1;
        with_out = 1'b0;
        rtype    = 8'($urandom) & ~TYPE_KIND_MASK;
        index    = 16'd0;
        value    = 16'd0;
        length   = 16'($urandom_range(0, 8));
        if (pick < 35) begin
            // descriptor read with a data stage of computed packet count
            case ($urandom_range(0, 4))
                0:       begin value = DESC_DEVICE;  size = {8'd0, dev_len};  end
                1:       begin value = DESC_CONFIG;  size = conf_len;         end
                2:       begin value = DESC_STRING0; size = {8'd0, str0_len}; end
                3:       begin value = DESC_STRING1; size = {8'd0, str1_len}; end
                default: begin value = 16'($urandom); size = 16'd0;           end
            endcase
            case ($urandom_range(0, 9))
                6:       length = size;
                7:       length = size + 16'd1;
                8:       length = (size > 16'd2000) ? 16'($urandom_range(0, 300)) : 16'hFFFF;
                9:       length = 16'($urandom_range(0, 1000));
                default: length = 16'($urandom_range(0, 200));
            endcase
            code  = REQ_GET_DESC;
            index = 16'($urandom);
            shown = (size < length) ? int'(size) : int'(length);
            n_in  = (shown + PACKET_SIZE_DEF - 1) / PACKET_SIZE_DEF;
            if (n_in == 0) n_in = 1;
            if (size < length && size % PACKET_SIZE_DEF == 0) n_in++;
            with_out = 1'b1;
        end else if (pick < 45) begin
            code  = REQ_SET_ADDRESS;
            value = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        end else if (pick < 60) begin
            code  = REQ_SET_CONFIG;
            value = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
        end else if (pick < 68) begin
            code     = $urandom_range(0, 1) ? REQ_GET_STATUS : REQ_GET_CONFIG;
            length   = 16'($urandom);
            with_out = 1'b1;
        end else if (pick < 76) begin
            code  = REQ_CLEAR_FEATURE;
            rtype = ($urandom_range(0, 4) == 0) ? rtype : TYPE_ENDPOINT;
            value = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
            case ($urandom_range(0, 4))
                0:       index = 16'($urandom);
                1, 2:    index = EP_BULK_OUT;
                default: index = EP_BULK_IN;
            endcase
        end else if (pick < 88) begin
            rtype = rtype | KIND_CLASS;
            case ($urandom_range(0, 4))
                0:       code = 8'($urandom);
                1, 2:    code = REQ_GET_MAX_LUN;
                default: code = REQ_STORAGE_RESET;
            endcase
            with_out = (code == REQ_GET_MAX_LUN);
            index    = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
        end else begin
            // noise: garbage setup or a lone stray beat
            case ($urandom_range(0, 3))
                0:       complete(MODE_SETUP);
                1:       complete(MODE_IN);
                2:       complete(MODE_OUT);
                default: complete(MODE_UNUSED);
            endcase
            return;
        end
        send_txn(MODE_SETUP, rtype, code, value, index, length);
        // now and then a transfer is cut short or overrun
        if ($urandom_range(0, 9) == 0) begin
            n_in     = $urandom_range(0, n_in + 1);
            with_out = $urandom_range(0, 1);
        end
        repeat (n_in) complete(MODE_IN);
        if (with_out) complete(MODE_OUT);
    endtask

    // Stimulus and verdict
    initial begin
        int phase;
        int first_random;
        int phase_start;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // stray beats while idle, including the undefined mode
        complete(MODE_IN);
        complete(MODE_OUT);
        complete(MODE_UNUSED);
        // device descriptor with the longest request, then status out
        send_txn(MODE_SETUP, 8'h80, REQ_GET_DESC, DESC_DEVICE, 16'h0000, 16'hFFFF);
        complete(MODE_IN);
        complete(MODE_IN);
        complete(MODE_OUT);
        // address from an all-ones wValue; stray OUT in status in
        send_txn(MODE_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000);
        complete(MODE_OUT);
        complete(MODE_IN);
        send_txn(MODE_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000);
        complete(MODE_IN);
        send_txn(MODE_SETUP, 8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001);
        complete(MODE_IN);
        complete(MODE_OUT);
        send_txn(MODE_SETUP, 8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002);
        complete(MODE_IN);
        send_txn(MODE_SETUP, TYPE_ENDPOINT, REQ_CLEAR_FEATURE, 16'h0000, EP_BULK_OUT, 16'h0);
        complete(MODE_IN);
        send_txn(MODE_SETUP, TYPE_ENDPOINT, REQ_CLEAR_FEATURE, 16'h0000, EP_BULK_IN, 16'h0);
        complete(MODE_IN);
        send_txn(MODE_SETUP, 8'hA1, REQ_GET_MAX_LUN, 16'h0000, 16'h0000, 16'h0001);
        send_txn(MODE_SETUP, 8'h21, REQ_STORAGE_RESET, 16'h0000, 16'h0000, 16'h0000);
        complete(MODE_IN);
        // vendor request, unknown descriptor, bad configuration: all stall
        send_txn(MODE_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_txn(MODE_SETUP, 8'h80, REQ_GET_DESC, 16'h0400, 16'h0000, 16'h0040);
        send_txn(MODE_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0002, 16'h0000, 16'h0000);
        send_txn(MODE_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0000, 16'h0000, 16'h0000);
        complete(MODE_IN);
        send_txn(MODE_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h0000, 16'h0000, 16'h0000);
        complete(MODE_IN);

        // multi-packet read closed by a zero-length packet, empty string, exact fit
        drain();
        program_lengths(8'd255, 16'd128, 8'd0, 8'd64);
        send_txn(MODE_SETUP, 8'h80, REQ_GET_DESC, DESC_CONFIG, 16'h0000, 16'hFFFF);
        repeat (3) complete(MODE_IN);
        complete(MODE_OUT);
        send_txn(MODE_SETUP, 8'h80, REQ_GET_DESC, DESC_STRING0, 16'h0409, 16'h0005);
        repeat (2) complete(MODE_IN);
        send_txn(MODE_SETUP, 8'h80, REQ_GET_DESC, DESC_STRING1, 16'h0409, 16'h0040);
        complete(MODE_IN);

        // random phases, each under its own descriptor lengths
        first_random = sent_items;
        phase        = 0;
        while (sent_items - first_random < RANDOM_ITEMS) begin
            drain();
            case (phase)
                0:       program_lengths(8'd0, 16'd0, 8'd0, 8'd0);
                1:       program_lengths(8'd255, 16'hFFFF, 8'd255, 8'd255);
                2:       program_lengths(8'd64, 16'd192, 8'd128, 8'd1);
                default: program_lengths(pick_len8(),
                                         ($urandom_range(0, 3) == 0) ? 16'd256
                                                                     : 16'($urandom_range(0, 300)),
                                         pick_len8(), pick_len8());
            endcase
            no_gaps     = (phase % 4 == 3);
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) random_transfer();
            phase++;
        end

        drain();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && replies_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ucep_pkg.sv
rtl/ucep_cfg.sv
rtl/ucep_core.sv
rtl/usb_control_endpoint_fsm_top.sv
rtl/ucep_checker.sv
tb/sv/ep0_result_check.sv
tb/sv/tb.sv
